FILE: src/ewma_pkg.sv
// ----------------------------------------------------------------------------
// ewma_pkg
// Shared types and constants for the source scorer and selector.
// ----------------------------------------------------------------------------
package ewma_pkg;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_ACCEPT = 2'd1,
    OP_REJECT = 2'd2,
    OP_JOB    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  source;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [3:0] active_source;
    logic       switched;
    logic [7:0] strikes;
  } out_item_t;

  localparam logic [31:0] LAT_RESET   = 32'd51200;
  localparam logic [16:0] ACC_RESET   = 17'd32768;
  localparam logic [16:0] ACC_ONE     = 17'd65536;
  localparam logic [31:0] INT_RESET   = 32'd15360000;
  localparam logic [63:0] PRIOR_SCORE = 64'd10683998;
  localparam logic [7:0]  LIMIT_RESET = 8'd5;

  // Divider request: 96-bit dividend by 33-bit divisor.
  typedef struct packed {
    logic        start;
    logic [95:0] num;
    logic [32:0] den;
  } div_req_t;

endpackage

FILE: src/ewma_div.sv
// ----------------------------------------------------------------------------
// ewma_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ewma_div
  import ewma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [95:0] quot
);

  logic [95:0] q;
  logic [32:0] den;
  logic [33:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] shifted;

  assign shifted = {rem[32:0], q[95]};
  assign trial   = shifted - {1'b0, den};
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q    <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= 7'd96;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial;
          q   <= {q[94:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[94:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/ewma_source_scorer_selector.sv
// ----------------------------------------------------------------------------
// ewma_source_scorer_selector
// Per-source EWMA scoring with strike-based selection of the active source.
// ----------------------------------------------------------------------------
// Use: events (op, source, timestamp) arrive on in_valid/in_ready; one result
// transaction (active source, switched flag, strikes) leaves on
// out_valid/out_ready for each event. The limit is written from cfg_data via cfg_we.
// Submit, plain job, out-of-range events and accepts with no pending submit
// or on an unscored source go straight to done; a job with an interval update
// uses one division, an averaged accept two (chained), a reject on a scored
// source one; a reject on the active source then scans every source, with two
// divisions per scored source, and makes the strike decision.
// One event is in flight at a time; a new event is accepted once the block
// is idle. The output register holds the result until taken; the following
// result waits in the done state until that register is free.
// Reset (rst, synchronous) restores all averages to their priors, clears the
// scored, pending and job flags, active source 0, strikes 0, limit 5.
// A stalled receiver simply holds the result; nothing is lost.
// ----------------------------------------------------------------------------
module ewma_source_scorer_selector
  import ewma_pkg::*;
#(
  parameter int SOURCE_COUNT = 4
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int IW = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_DIV1  = 9'b000000100,
    S_WAIT1 = 9'b000001000,
    S_DIV2  = 9'b000010000,
    S_WAIT2 = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_SWAIT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // Per-source state, small register arrays indexed by the event's source.
  logic [31:0] lat   [SOURCE_COUNT];
  logic [16:0] acc   [SOURCE_COUNT];
  logic [31:0] intv  [SOURCE_COUNT];
  logic [31:0] pend  [SOURCE_COUNT];
  logic [31:0] pjob  [SOURCE_COUNT];
  logic [SOURCE_COUNT-1:0] pvalid, jvalid, scored;

  logic [IW-1:0] active;
  logic [7:0]    strikes, limit;
  in_item_t      ev;
  logic [IW-1:0] sidx;
  logic          sw;

  // Divider sharing
  div_req_t    dreq;
  logic        ddone;
  logic [95:0] dq;

  ewma_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dq));

  // Scan state
  logic [IW-1:0] scan;
  logic          sphase;   // 0: divide by interval, 1: by latency
  logic [63:0]   best_sc;
  logic [IW-1:0] best;
  logic          do_acc;   // second division is acceptance update

  // result may be loaded into the output register this cycle
  logic          out_load;

  assign sidx = ev.source[IW-1:0];

  function automatic logic [31:0] q8sat(input logic [31:0] ms);
    q8sat = (ms[31:24] != 8'd0) ? 32'hFFFFFFFF : {ms[23:0], 8'd0};
  endfunction

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  logic in_range;
  assign in_range = ({28'd0, in_data.source} < 32'(SOURCE_COUNT));

  // Event FSM; the scan scores a scored source via two chained divisions, else prior.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      active    <= '0;
      strikes   <= '0;
      limit     <= LIMIT_RESET;
      pvalid    <= '0;
      jvalid    <= '0;
      scored    <= '0;
      dreq      <= '0;
      for (int i = 0; i < SOURCE_COUNT; i++) begin
        lat[i]  <= LAT_RESET;
        acc[i]  <= ACC_RESET;
        intv[i] <= INT_RESET;
        pend[i] <= '0;
        pjob[i] <= '0;
      end
    end else begin
      dreq.start <= 1'b0;
      if (cfg_we) limit <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            ev <= in_data;
            sw <= 1'b0;
            state <= in_range ? S_DEC : S_DONE;
          end
        end
        S_DEC: begin
          case (op_t'(ev.op))
            OP_SUBMIT: begin
              pend[sidx]   <= ev.timestamp;
              pvalid[sidx] <= 1'b1;
              state <= S_DONE;
            end
            OP_ACCEPT: begin
              strikes <= '0;
              if (!pvalid[sidx]) begin
                state <= S_DONE;
              end else if (!scored[sidx]) begin
                lat[sidx]    <= q8sat(ev.timestamp - pend[sidx]);
                acc[sidx]    <= ACC_ONE;
                scored[sidx] <= 1'b1;
                pvalid[sidx] <= 1'b0;
                pend[sidx]   <= '0;
                state <= S_DONE;
              end else begin
                // new lat average = (x + 9*old + 5) / 10
                dreq.start <= 1'b1;
                dreq.num <= 96'({4'd0, q8sat(ev.timestamp - pend[sidx])})
                          + 96'(lat[sidx]) * 96'd9 + 96'd5;
                dreq.den <= 33'd10;
                do_acc <= 1'b1;
                pvalid[sidx] <= 1'b0;
                pend[sidx]   <= '0;
                state <= S_WAIT1;
              end
            end
            OP_REJECT: begin
              if (scored[sidx]) begin
                // acceptance: (4*old + 2) / 5
                dreq.start <= 1'b1;
                dreq.num   <= 96'(acc[sidx]) * 96'd4 + 96'd2;
                dreq.den   <= 33'd5;
                do_acc <= 1'b0;
                state <= S_WAIT2;
              end else begin
                state <= S_DIV2;
              end
            end
            default: begin
              if (jvalid[sidx] && ev.timestamp != pjob[sidx]) begin
                dreq.start <= 1'b1;
                dreq.num <= 96'(q8sat(ev.timestamp - pjob[sidx])) * 96'd3
                          + 96'(intv[sidx]) * 96'd17 + 96'd10;
                dreq.den <= 33'd20;
                scored[sidx] <= 1'b1;
                do_acc <= 1'b0;
                state <= S_WAIT1;
              end else begin
                state <= S_DONE;
              end
              pjob[sidx]   <= ev.timestamp;
              jvalid[sidx] <= 1'b1;
            end
          endcase
        end
        S_WAIT1: begin
          if (ddone) begin
            if (op_t'(ev.op) == OP_JOB) begin
              intv[sidx] <= dq[31:0];
              state <= S_DONE;
            end else begin
              lat[sidx] <= dq[31:0];
              // acceptance toward one: (65536 + 4*old + 2) / 5
              dreq.start <= 1'b1;
              dreq.num   <= 96'(acc[sidx]) * 96'd4 + 96'd65538;
              dreq.den   <= 33'd5;
              state <= S_WAIT2;
            end
          end
        end
        S_WAIT2: begin
          if (ddone) begin
            acc[sidx] <= dq[16:0];
            state <= (do_acc || op_t'(ev.op) != OP_REJECT) ? S_DONE : S_DIV2;
          end
        end
        S_DIV2: begin
          // reject: start the scan only on the active source
          if (sidx == active) begin
            scan    <= '0;
            sphase  <= 1'b0;
            best    <= '0;
            best_sc <= '0;
            state   <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (!scored[scan]) begin
            if (scan == '0 || PRIOR_SCORE > best_sc) begin
              best_sc <= PRIOR_SCORE;
              best    <= scan;
            end
            if (32'(scan) == SOURCE_COUNT - 1) state <= S_DIV1;
            else scan <= scan + 1'b1;
          end else begin
            dreq.start <= 1'b1;
            dreq.num   <= {96'(acc[scan]) * 96'd1000} << 32;
            dreq.den   <= {1'b0, intv[scan]} + 33'd256;
            sphase     <= 1'b0;
            state      <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (ddone) begin
            if (!sphase) begin
              dreq.start <= 1'b1;
              dreq.num   <= dq;
              dreq.den   <= {1'b0, lat[scan]} + 33'd256;
              sphase     <= 1'b1;
            end else begin
              if (scan == '0 || dq[63:0] > best_sc) begin
                best_sc <= dq[63:0];
                best    <= scan;
              end
              if (32'(scan) == SOURCE_COUNT - 1) state <= S_DIV1;
              else begin
                scan  <= scan + 1'b1;
                state <= S_SCAN;
              end
            end
          end
        end
        S_DIV1: begin
          // strike decision after the scan
          if (best != active) begin
            if (((strikes == 8'd255) ? strikes : strikes + 8'd1) >= limit) begin
              active  <= best;
              strikes <= '0;
              sw      <= 1'b1;
            end else if (strikes != 8'd255) begin
              strikes <= strikes + 8'd1;
            end
          end else begin
            strikes <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hold here while the previous result is still unclaimed
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.active_source <= 4'(active);
      out_data.switched      <= sw;
      out_data.strikes       <= strikes;
    end
  end

endmodule
